// ===== sv/ccc_pkg.sv =====
// Package for the calling-convention checker: sizes, codes, word types
// and the command and status structs that join controller and datapath.
// No dependencies.
package ccc_pkg;

  localparam int STACK_WORDS = 4096;
  localparam int FRAME_DEPTH = 64;
  localparam int SREG_COUNT  = 12;
  localparam int TRK_COUNT   = 14;
  localparam int SW_BITS     = $clog2(STACK_WORDS);
  localparam int FD_BITS     = $clog2(FRAME_DEPTH);
  localparam int FC_BITS     = $clog2(FRAME_DEPTH + 1);
  localparam int CAL_DEPTH   = FRAME_DEPTH * SREG_COUNT;
  localparam int CAL_BITS    = $clog2(CAL_DEPTH);
  localparam int CFG_IDX_BITS = 1;

  localparam logic [7:0]  UNWRITTEN       = 8'hFF;
  localparam logic [31:0] RESET_READABLE  = 32'h0FFC_031D;
  localparam logic [31:0] CALL_ACCESSIBLE = 32'h0FFF_FF1F;
  localparam logic [31:0] CALL_CLOBBERED  = 32'hF003_F0E0;
  localparam logic [31:0] A0A1_BITS       = 32'h0000_0C00;
  localparam logic [31:0] RESET_TOP_ADDR  = 32'h8000_0000;
  localparam logic [31:0] STACK_BYTES     = 32'(STACK_WORDS * 4);
  localparam logic [3:0]  LAST_SREG       = 4'(SREG_COUNT - 1);
  localparam logic [4:0]  REG_RA          = 5'd1;
  localparam logic [4:0]  REG_SP          = 5'd2;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_CALL  = 3'd2,
    REQ_RET   = 3'd3,
    REQ_STORE = 3'd4,
    REQ_LOAD  = 3'd5
  } req_kind_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_NEVER     = 4'd1,
    ERR_CLOBBERED = 4'd2,
    ERR_SP_INV    = 4'd3,
    ERR_RET_EMPTY = 4'd4,
    ERR_SP_MIS    = 4'd5,
    ERR_RA_MIS    = 4'd6,
    ERR_NOT_SAVED = 4'd7,
    ERR_OVERFLOW  = 4'd8,
    ERR_UNWR_LOAD = 4'd9
  } err_code_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLE   = 1'b0,
    CFG_TOP_ADDR = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_CALL_SAVE,
    S_RET_CHK,
    S_RET_REG,
    S_POISON,
    S_ST_HI,
    S_LD_HI,
    S_LD_CHK,
    S_HOLD
  } state_t;

  typedef enum logic [1:0] {
    WW_CNT,
    WW_LO,
    WW_HI
  } ww_src_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] addr;
    logic [3:0]  access_size;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  error_code;
    logic [31:0] error_subject;
    logic [31:0] expected_value;
  } rsp_t;

  typedef struct packed {
    logic      req_load;
    logic      span_latch;
    logic      do_write;
    logic      call_push;
    logic      call_save;
    logic      call_done;
    logic      ret_pop;
    logic      cal_rd;
    logic      ret_restore;
    logic      ww_we;
    ww_src_t   ww_src;
    logic      ww_rd;
    logic      ww_rd_hi;
    logic      ld_flag_set;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      fin;
    err_code_t fin_code;
    logic      hold_out;
  } ccc_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       en;
    logic       rd_fail;
    logic       rd_clob;
    logic       sp_ok;
    logic       fc_zero;
    logic       fc_full;
    logic       span_ok;
    logic       sp_mis;
    logic       ra_mis;
    logic       reg_mis;
    logic       k_last;
    logic       poison_zero;
    logic       poison_last;
    logic       clear_last;
    logic       ld_unwr;
    logic       out_free;
  } ccc_stat_t;

  // Tracked slot of a register: hit flag then slot (sp, ra, fp, s1, s2..s11).
  function automatic logic [4:0] slot_of(input logic [4:0] r);
    logic [4:0] t;
    t = r - 5'd14;
    case (r)
      5'd2:    slot_of = {1'b1, 4'd0};
      5'd1:    slot_of = {1'b1, 4'd1};
      5'd8:    slot_of = {1'b1, 4'd2};
      5'd9:    slot_of = {1'b1, 4'd3};
      default: slot_of = (r >= 5'd18 && r <= 5'd27) ? {1'b1, t[3:0]} : 5'd0;
    endcase
  endfunction

  // Register number of callee-saved slot k (fp, s1, then s2 onwards).
  function automatic logic [4:0] sreg_num(input logic [3:0] k);
    case (k)
      4'd0:    sreg_num = 5'd8;
      4'd1:    sreg_num = 5'd9;
      default: sreg_num = 5'(k) + 5'd16;
    endcase
  endfunction

endpackage

// ===== sv/ccc_ctrl.sv =====
// Controller state machine of the calling-convention checker.
// Depends on ccc_pkg; drives the datapath through ccc_cmd_t.
module ccc_ctrl import ccc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  ccc_stat_t stat,
  output ccc_cmd_t  cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = (state != S_IDLE);
    case (state)
      S_CLEAR: begin
        cmd.ww_we   = 1'b1;
        cmd.ww_src  = WW_CNT;
        cmd.cnt_inc = 1'b1;
        if (stat.clear_last) begin
          cmd.cnt_inc = 1'b0;
          cmd.cnt_clr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.span_latch = 1'b1;
        cmd.fin        = 1'b1;
        cmd.fin_code   = ERR_NONE;
        if (!stat.en) begin
          cmd.do_write = (stat.req_type == REQ_WRITE);
        end else begin
          case (stat.req_type)
            REQ_READ: begin
              if (stat.rd_fail) begin
                cmd.fin_code = stat.rd_clob ? ERR_CLOBBERED : ERR_NEVER;
              end
            end
            REQ_WRITE: begin
              cmd.do_write = 1'b1;
            end
            REQ_CALL: begin
              if (!stat.sp_ok) begin
                cmd.fin_code = ERR_SP_INV;
              end else if (stat.fc_full) begin
                cmd.fin_code = ERR_OVERFLOW;
              end else begin
                cmd.fin       = 1'b0;
                cmd.call_push = 1'b1;
                cmd.cnt_clr   = 1'b1;
              end
            end
            REQ_RET: begin
              if (stat.fc_zero) begin
                cmd.fin_code = ERR_RET_EMPTY;
              end else begin
                cmd.fin     = 1'b0;
                cmd.ret_pop = 1'b1;
              end
            end
            REQ_STORE: begin
              if (stat.span_ok) begin
                cmd.fin    = 1'b0;
                cmd.ww_we  = 1'b1;
                cmd.ww_src = WW_LO;
              end
            end
            REQ_LOAD: begin
              if (stat.span_ok) begin
                cmd.fin   = 1'b0;
                cmd.ww_rd = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if (!cmd.fin) begin
          case (stat.req_type)
            REQ_CALL:  state_next = S_CALL_SAVE;
            REQ_RET:   state_next = S_RET_CHK;
            REQ_STORE: state_next = S_ST_HI;
            default:   state_next = S_LD_HI;
          endcase
        end
      end
      S_CALL_SAVE: begin
        cmd.call_save = 1'b1;
        if (stat.k_last) begin
          cmd.call_done = 1'b1;
          cmd.fin       = 1'b1;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_RET_CHK: begin
        if (stat.sp_mis) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = ERR_SP_MIS;
        end else if (!stat.sp_ok) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = ERR_SP_INV;
        end else if (stat.ra_mis) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = ERR_RA_MIS;
        end else begin
          cmd.cnt_clr = 1'b1;
          cmd.cal_rd  = 1'b1;
          state_next  = S_RET_REG;
        end
      end
      S_RET_REG: begin
        if (stat.reg_mis) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = ERR_NOT_SAVED;
        end else if (stat.k_last) begin
          cmd.ret_restore = 1'b1;
          cmd.cnt_clr     = 1'b1;
          if (stat.poison_zero) begin
            cmd.fin = 1'b1;
          end else begin
            state_next = S_POISON;
          end
        end else begin
          cmd.cnt_inc = 1'b1;
          cmd.cal_rd  = 1'b1;
        end
      end
      S_POISON: begin
        cmd.ww_we  = 1'b1;
        cmd.ww_src = WW_CNT;
        if (stat.poison_last) begin
          cmd.cnt_clr = 1'b1;
          cmd.fin     = 1'b1;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_ST_HI: begin
        cmd.ww_we  = 1'b1;
        cmd.ww_src = WW_HI;
        cmd.fin    = 1'b1;
      end
      S_LD_HI: begin
        cmd.ww_rd       = 1'b1;
        cmd.ww_rd_hi    = 1'b1;
        cmd.ld_flag_set = 1'b1;
        state_next      = S_LD_CHK;
      end
      S_LD_CHK: begin
        cmd.fin      = 1'b1;
        cmd.fin_code = stat.ld_unwr ? ERR_UNWR_LOAD : ERR_NONE;
      end
      S_HOLD: begin
        if (stat.out_free) begin
          cmd.hold_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // A finished word goes out now, or waits in the hold register.
    if (cmd.fin) begin
      state_next = stat.out_free ? S_IDLE : S_HOLD;
    end
  end

endmodule

// ===== sv/ccc_dp.sv =====
// Datapath of the calling-convention checker: configuration, masks,
// tracked registers, shadow stack, stack word map and result registers.
// Depends on ccc_pkg; commanded by ccc_ctrl.
module ccc_dp import ccc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  req_t                    req,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data,
  input  ccc_cmd_t                cmd,
  output ccc_stat_t               stat,
  output logic                    rsp_valid,
  output rsp_t                    rsp,
  input  logic                    rsp_stall
);

  logic               enable;
  logic [31:0]        top_addr;
  logic [31:0]        stack_base;
  req_t               cur;
  logic [31:0]        readable;
  logic [31:0]        ever;
  logic [31:0]        tracked [TRK_COUNT];
  logic [FC_BITS-1:0] fc;
  logic [SW_BITS-1:0] cnt;
  logic [SW_BITS-1:0] hi;
  logic [SW_BITS:0]   phi;
  logic               ld_flag;
  rsp_t               hold;

  logic [31:0] cal_mem [CAL_DEPTH];
  logic [31:0] sp_mem  [FRAME_DEPTH];
  logic [31:0] ra_mem  [FRAME_DEPTH];
  logic [31:0] map_mem [FRAME_DEPTH];
  logic [7:0]  ww_mem  [STACK_WORDS];
  logic [31:0] cal_q, sp_q, ra_q, map_q;
  logic [7:0]  ww_q;

  logic [3:0]         k, k_next, k_trk;
  logic [31:0]        trk_sel, sp, ra;
  logic [31:0]        sz, off;
  logic [32:0]        hi_sum;
  logic [29:0]        lo_w, pq;
  logic [30:0]        hi_w;
  logic [31:0]        pd;
  logic [SW_BITS-1:0] lo_c, hi_c, ww_waddr, ww_raddr;
  logic [SW_BITS:0]   phi_c;
  logic [7:0]         ww_wdata;
  logic [FD_BITS-1:0] fidx;
  logic [FC_BITS-1:0] fc_m1;
  logic [CAL_BITS-1:0] cal_waddr, cal_raddr;
  logic [4:0]         slot;
  rsp_t               fin_rsp;
  logic               out_free;

  // Selections shared by the checks.
  always_comb begin
    k        = cnt[3:0];
    k_next   = cmd.cnt_clr ? 4'd0 : (cmd.cnt_inc ? k + 4'd1 : k);
    k_trk    = (k > LAST_SREG) ? 4'd2 : k + 4'd2;
    trk_sel  = tracked[k_trk];
    sp       = tracked[0];
    ra       = tracked[1];
    slot     = slot_of(cur.reg_index);
    fidx     = fc[FD_BITS-1:0];
    fc_m1    = fc - FC_BITS'(1);
    cal_waddr = CAL_BITS'(fidx) * CAL_BITS'(SREG_COUNT) + CAL_BITS'(k);
    cal_raddr = CAL_BITS'(fidx) * CAL_BITS'(SREG_COUNT) + CAL_BITS'(k_next);
  end

  // Word span of a stack access, clamped to the map.
  always_comb begin
    sz     = 32'(cur.access_size);
    off    = cur.addr - stack_base;
    hi_sum = {1'b0, off} + 33'(sz) - 33'd1;
    lo_w   = off[31:2];
    hi_w   = hi_sum[32:2];
    lo_c   = (lo_w >= 30'(STACK_WORDS)) ? SW_BITS'(STACK_WORDS - 1) : lo_w[SW_BITS-1:0];
    hi_c   = (hi_w >= 31'(STACK_WORDS)) ? SW_BITS'(STACK_WORDS - 1) : hi_w[SW_BITS-1:0];
    pd     = sp_q - stack_base;
    pq     = pd[31:2];
    phi_c  = (pq > 30'(STACK_WORDS)) ? (SW_BITS+1)'(STACK_WORDS) : pq[SW_BITS:0];
  end

  // Status to the controller.
  always_comb begin
    out_free         = !rsp_valid || !rsp_stall;
    stat.req_type    = cur.req_type;
    stat.en          = enable;
    stat.rd_fail     = (cur.reg_index != 5'd0) && !readable[cur.reg_index];
    stat.rd_clob     = ever[cur.reg_index];
    stat.sp_ok       = (sp >= stack_base) && (sp <= top_addr);
    stat.fc_zero     = (fc == '0);
    stat.fc_full     = (fc >= FC_BITS'(FRAME_DEPTH));
    stat.span_ok     = (cur.addr >= stack_base) && (cur.addr < top_addr) &&
                       (sz != 32'd0) && (sz <= top_addr - cur.addr);
    stat.sp_mis      = (sp != sp_q);
    stat.ra_mis      = (ra != ra_q);
    stat.reg_mis     = (trk_sel != cal_q);
    stat.k_last      = (k == LAST_SREG);
    stat.poison_zero = (phi_c == '0);
    stat.poison_last = ((SW_BITS+1)'(cnt) + (SW_BITS+1)'(1) == phi);
    stat.clear_last  = (cnt == SW_BITS'(STACK_WORDS - 1));
    stat.ld_unwr     = ld_flag || (ww_q == UNWRITTEN);
    stat.out_free    = out_free;
  end

  // Result word for the finishing step.
  always_comb begin
    fin_rsp.ok             = (cmd.fin_code == ERR_NONE);
    fin_rsp.error_code     = cmd.fin_code;
    fin_rsp.error_subject  = '0;
    fin_rsp.expected_value = '0;
    case (cmd.fin_code)
      ERR_NEVER, ERR_CLOBBERED: fin_rsp.error_subject = 32'(cur.reg_index);
      ERR_SP_INV:    fin_rsp.error_subject = sp;
      ERR_SP_MIS: begin
        fin_rsp.error_subject  = 32'(REG_SP);
        fin_rsp.expected_value = sp_q;
      end
      ERR_RA_MIS: begin
        fin_rsp.error_subject  = 32'(REG_RA);
        fin_rsp.expected_value = ra_q;
      end
      ERR_NOT_SAVED: begin
        fin_rsp.error_subject  = 32'(sreg_num(k));
        fin_rsp.expected_value = cal_q;
      end
      ERR_UNWR_LOAD: fin_rsp.error_subject = cur.addr;
      default: begin
      end
    endcase
  end

  // Stack map port selection.
  always_comb begin
    case (cmd.ww_src)
      WW_LO:   ww_waddr = lo_c;
      WW_HI:   ww_waddr = hi;
      default: ww_waddr = cnt;
    endcase
    ww_wdata = (cmd.ww_src == WW_CNT) ? UNWRITTEN : 8'(cur.reg_index);
    ww_raddr = cmd.ww_rd_hi ? hi : lo_c;
  end

  // Control state: configuration, masks, tracked values, counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      top_addr   <= RESET_TOP_ADDR;
      stack_base <= RESET_TOP_ADDR - STACK_BYTES;
      readable   <= RESET_READABLE;
      ever       <= '0;
      fc         <= '0;
      cnt        <= '0;
      rsp_valid  <= 1'b0;
      for (int i = 0; i < TRK_COUNT; i++) begin
        tracked[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ENABLE: enable <= cfg_data[0];
          CFG_TOP_ADDR: begin
            top_addr   <= cfg_data;
            stack_base <= cfg_data - STACK_BYTES;
          end
          default: begin
          end
        endcase
      end
      if (cmd.do_write && slot[4]) begin
        tracked[slot[3:0]] <= cur.reg_value;
      end
      if (cmd.do_write && enable) begin
        readable <= readable | (32'd1 << cur.reg_index);
        ever     <= ever | (32'd1 << cur.reg_index);
      end else if (cmd.call_done) begin
        readable <= readable & CALL_ACCESSIBLE;
      end else if (cmd.ret_restore) begin
        readable <= (map_q & ~CALL_CLOBBERED) | (readable & A0A1_BITS);
      end
      if (cmd.call_done) begin
        fc <= fc + FC_BITS'(1);
      end else if (cmd.ret_pop) begin
        fc <= fc_m1;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + SW_BITS'(1);
      end
      if (cmd.fin && out_free) begin
        rsp_valid <= 1'b1;
      end else if (cmd.hold_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      cur <= req;
    end
    if (cmd.span_latch) begin
      hi <= hi_c;
    end
    if (cmd.ret_restore) begin
      phi <= phi_c;
    end
    if (cmd.ld_flag_set) begin
      ld_flag <= (ww_q == UNWRITTEN);
    end
    if (cmd.fin && out_free) begin
      rsp <= fin_rsp;
    end else if (cmd.fin) begin
      hold <= fin_rsp;
    end else if (cmd.hold_out) begin
      rsp <= hold;
    end
  end

  // Shadow stack memories.
  always_ff @(posedge clk) begin
    if (cmd.call_save) begin
      cal_mem[cal_waddr] <= trk_sel;
    end
    if (cmd.cal_rd) begin
      cal_q <= cal_mem[cal_raddr];
    end
    if (cmd.call_push) begin
      sp_mem[fidx]  <= sp;
      ra_mem[fidx]  <= ra;
      map_mem[fidx] <= readable;
    end
    if (cmd.ret_pop) begin
      sp_q  <= sp_mem[fc_m1[FD_BITS-1:0]];
      ra_q  <= ra_mem[fc_m1[FD_BITS-1:0]];
      map_q <= map_mem[fc_m1[FD_BITS-1:0]];
    end
  end

  // Stack word writer map.
  always_ff @(posedge clk) begin
    if (cmd.ww_we) begin
      ww_mem[ww_waddr] <= ww_wdata;
    end
    if (cmd.ww_rd) begin
      ww_q <= ww_mem[ww_raddr];
    end
  end

endmodule

// ===== sv/calling_convention_checker.sv =====
// Calls save one callee-saved register each cycle; returns check and then restore,
// plus a map write for each poisoned stack word.
// One item at a time; a word meeting a full output register waits in a hold register.
// Reset is synchronous; afterwards a clearing pass marks every stack word
// unwritten before the first item is taken.
module calling_convention_checker import ccc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  req_t                    req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output rsp_t                    rsp,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data
);

  ccc_cmd_t  cmd;
  ccc_stat_t stat;

  assign cfg_ready = 1'b1;

  ccc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
  );

  // The stack map is being cleared straight after reset.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall) else $error("item taken during clearing pass");

  // A result word only appears from work on an accepted item.
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall)) else $error("result without work");

  // The shadow stack is never pushed when full.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.call_push |-> !stat.fc_full) else $error("push onto full shadow stack");

endmodule

// ===== verif/ccc_scoreboard.sv =====
`timescale 1ns / 100ps
// Checker for the calling-convention checker: it watches the request, response
// and register channels, predicts each response and compares it field by field.
// Depends on ccc_pkg for the word types, sizes and codes.
module ccc_scoreboard import ccc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic                    req_stall,
  input  req_t                    req,
  input  logic                    rsp_valid,
  input  logic                    rsp_stall,
  input  rsp_t                    rsp,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data,
  output int                      pending,
  output int                      failures,
  output int                      words_seen,
  output int                      errors_seen
);

  // Predicted copy of the block's registers and state.
  logic        chk_on;
  logic [31:0] top_addr;
  logic [31:0] readable, ever_written;
  logic [31:0] live_val [TRK_COUNT];
  logic [31:0] frame_regs [FRAME_DEPTH][SREG_COUNT];
  logic [31:0] frame_sp [FRAME_DEPTH];
  logic [31:0] frame_ra [FRAME_DEPTH];
  logic [31:0] frame_mask [FRAME_DEPTH];
  int          depth;
  logic [7:0]  writer [STACK_WORDS];
  rsp_t        awaited [$];

  // Slot holding a tracked register: sp, ra, fp, s1, then s2..s11; -1 if untracked.
  function automatic int track_slot(input logic [4:0] r);
    if (r == REG_SP) return 0;
    if (r == REG_RA) return 1;
    if (r == 5'd8) return 2;
    if (r == 5'd9) return 3;
    if (r >= 5'd18 && r <= 5'd27) return int'(r) - 14;
    return -1;
  endfunction

  function automatic logic [31:0] base_addr();
    return top_addr - STACK_BYTES;
  endfunction

  function automatic bit sp_in_stack(input logic [31:0] sp);
    return sp >= base_addr() && sp <= top_addr;
  endfunction

  // Word span of an access lying wholly inside the stack.
  function automatic bit word_span(input logic [31:0] a, input logic [3:0] sz,
                                   output int lo, output int hi);
    logic [31:0] off;
    lo = 0;
    hi = 0;
    if (!(a >= base_addr() && a < top_addr && sz != 0 && 32'(sz) <= top_addr - a))
      return 0;
    off = a - base_addr();
    lo = int'(off / 4);
    hi = int'((off + 32'(sz) - 1) / 4);
    if (lo >= STACK_WORDS) lo = STACK_WORDS - 1;
    if (hi >= STACK_WORDS) hi = STACK_WORDS - 1;
    return 1;
  endfunction

  // Works out the response to one request and advances the predicted state.
  task automatic judge_request(input req_t r);
    rsp_t        e;
    err_code_t   code;
    logic [31:0] subj, expv, poison;
    int          s, f, lo, hi;
    code = ERR_NONE;
    subj = '0;
    expv = '0;
    if (r.req_type == REQ_WRITE) begin
      s = track_slot(r.reg_index);
      if (s >= 0) live_val[s] = r.reg_value;
    end
    if (chk_on) begin
      case (r.req_type)
        REQ_READ: begin
          if (r.reg_index != 0 && !readable[r.reg_index]) begin
            subj = 32'(r.reg_index);
            code = ever_written[r.reg_index] ? ERR_CLOBBERED : ERR_NEVER;
          end
        end
        REQ_WRITE: begin
          readable[r.reg_index] = 1'b1;
          ever_written[r.reg_index] = 1'b1;
        end
        REQ_CALL: begin
          if (!sp_in_stack(live_val[0])) begin
            code = ERR_SP_INV;
            subj = live_val[0];
          end else if (depth >= FRAME_DEPTH) begin
            code = ERR_OVERFLOW;
          end else begin
            for (int k = 0; k < SREG_COUNT; k++) frame_regs[depth][k] = live_val[2 + k];
            frame_sp[depth] = live_val[0];
            frame_ra[depth] = live_val[1];
            frame_mask[depth] = readable;
            depth++;
            readable &= CALL_ACCESSIBLE;
          end
        end
        REQ_RET: begin
          if (depth == 0) begin
            code = ERR_RET_EMPTY;
          end else begin
            depth--;
            f = depth;
            if (live_val[0] != frame_sp[f]) begin
              code = ERR_SP_MIS;
              subj = 32'(REG_SP);
              expv = frame_sp[f];
            end else if (!sp_in_stack(live_val[0])) begin
              code = ERR_SP_INV;
              subj = live_val[0];
            end else if (live_val[1] != frame_ra[f]) begin
              code = ERR_RA_MIS;
              subj = 32'(REG_RA);
              expv = frame_ra[f];
            end else begin
              for (int k = 0; k < SREG_COUNT; k++) begin
                if (code == ERR_NONE && live_val[2 + k] != frame_regs[f][k]) begin
                  code = ERR_NOT_SAVED;
                  subj = (k == 0) ? 32'd8 : (k == 1) ? 32'd9 : 32'(16 + k);
                  expv = frame_regs[f][k];
                end
              end
              if (code == ERR_NONE) begin
                readable = (frame_mask[f] & ~CALL_CLOBBERED) | (readable & A0A1_BITS);
                poison = (frame_sp[f] - base_addr()) / 4;
                if (poison > STACK_WORDS) poison = STACK_WORDS;
                for (int i = 0; i < int'(poison); i++) writer[i] = UNWRITTEN;
              end
            end
          end
        end
        REQ_STORE: begin
          if (word_span(r.addr, r.access_size, lo, hi)) begin
            writer[lo] = 8'(r.reg_index);
            writer[hi] = 8'(r.reg_index);
          end
        end
        REQ_LOAD: begin
          if (word_span(r.addr, r.access_size, lo, hi) &&
              (writer[lo] == UNWRITTEN || writer[hi] == UNWRITTEN)) begin
            code = ERR_UNWR_LOAD;
            subj = r.addr;
          end
        end
        default: ;
      endcase
    end
    e.ok = (code == ERR_NONE);
    e.error_code = code;
    e.error_subject = subj;
    e.expected_value = expv;
    awaited.push_back(e);
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    failures++;
  endtask

  // Observe the three channels at each edge.
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      chk_on <= 1'b1;
      top_addr = RESET_TOP_ADDR;
      readable = RESET_READABLE;
      ever_written = '0;
      for (int i = 0; i < TRK_COUNT; i++) live_val[i] = '0;
      for (int i = 0; i < STACK_WORDS; i++) writer[i] = UNWRITTEN;
      depth = 0;
      awaited.delete();
      pending <= 0;
      failures = 0;
      words_seen = 0;
      errors_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == CFG_ENABLE) chk_on <= cfg_data[0];
        else top_addr = cfg_data;
      end
      if (req_valid && !req_stall) judge_request(req);
      if (rsp_valid && !rsp_stall) begin
        words_seen++;
        if (!rsp.ok) errors_seen++;
        if (awaited.size() == 0) begin
          report_mismatch("unexpected word", '0, 32'(rsp.error_code));
        end else begin
          e = awaited.pop_front();
          if (rsp.ok != e.ok) report_mismatch("ok", 32'(e.ok), 32'(rsp.ok));
          if (rsp.error_code != e.error_code)
            report_mismatch("error_code", 32'(e.error_code), 32'(rsp.error_code));
          if (rsp.error_subject != e.error_subject)
            report_mismatch("error_subject", e.error_subject, rsp.error_subject);
          if (rsp.expected_value != e.expected_value)
            report_mismatch("expected_value", e.expected_value, rsp.expected_value);
        end
      end
      pending <= awaited.size();
    end
  end

endmodule

// ===== verif/tb_calling_convention_checker.sv =====
`timescale 1ns / 100ps
// Testbench top for the calling-convention checker: clock, reset, request and
// register traffic, response back-pressure, watchdog and verdict.
// Depends on ccc_pkg, calling_convention_checker and ccc_scoreboard.
module tb_calling_convention_checker;
  import ccc_pkg::*;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int         STALL_LIMIT = 30000;

  logic                    clk, rst;
  logic                    req_valid, req_stall, rsp_valid, rsp_stall;
  req_t                    req;
  rsp_t                    rsp;
  logic                    cfg_valid, cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [31:0]             cfg_data;
  int                      pending, failures, words_seen, errors_seen;
  int                      sent, quiet_left, cycle_no, idle_run;
  logic [31:0]             cur_top;

  calling_convention_checker uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ccc_scoreboard sb (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures),
    .words_seen(words_seen), .errors_seen(errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: random stalls, one quiet stretch, and one long hold-off
  // while requests keep coming so that the block backs up.
  initial begin
    rsp_stall = 1'b0;
    cycle_no = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no == 5000) begin
        rsp_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      if (cycle_no > 12000 && cycle_no < 30000) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  initial begin
    idle_run = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (cfg_valid && cfg_ready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic req_t pack_req(input logic [2:0] kind, input logic [4:0] r,
                                    input logic [31:0] v, input logic [31:0] a,
                                    input logic [3:0] sz);
    req_t q;
    q.req_type = kind;
    q.reg_index = r;
    q.reg_value = v;
    q.addr = a;
    q.access_size = sz;
    return q;
  endfunction

  // Offers one word and holds it until taken; random gaps before it.
  task automatic offer(input req_t q);
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 99) < 20) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= q;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOP_ADDR) cur_top = d;
  endtask

  function automatic logic [31:0] pick_sp();
    logic [31:0] base;
    base = cur_top - STACK_BYTES;
    if ($urandom_range(0, 99) < 88) return base + 4 * $urandom_range(0, 63);
    return base + $urandom_range(0, STACK_WORDS * 4);
  endfunction

  function automatic logic [4:0] pick_sreg();
    int k;
    k = $urandom_range(0, SREG_COUNT - 1);
    return (k == 0) ? 5'd8 : (k == 1) ? 5'd9 : 5'(16 + k);
  endfunction

  // Fully random word, any type, any field value.
  task automatic offer_noise();
    offer(pack_req(3'($urandom_range(0, 7)), 5'($urandom), $urandom, $urandom,
                   4'($urandom)));
  endtask

  // Work done inside a frame: reads, scratch writes, stack traffic near sp.
  task automatic offer_body(input logic [31:0] sp);
    logic [31:0] a;
    case ($urandom_range(0, 4))
      0: offer(pack_req(REQ_READ, 5'($urandom), '0, '0, '0));
      1: offer(pack_req(REQ_WRITE, 5'($urandom_range(10, 17)), $urandom, '0, '0));
      2, 3: begin
        a = sp - 4 * $urandom_range(0, 24) + $urandom_range(0, 3);
        offer(pack_req(REQ_STORE, 5'($urandom), '0, a, 4'($urandom_range(1, 8))));
      end
      default: begin
        a = sp - 4 * $urandom_range(0, 24) + $urandom_range(0, 3);
        offer(pack_req(REQ_LOAD, '0, '0, a, 4'($urandom_range(0, 15))));
      end
    endcase
  endtask

  // A well-formed call and return with random content, sometimes nested and
  // sometimes broken by a stray write to sp, ra or a callee-saved register.
  task automatic run_frame(input int level);
    logic [31:0] sp;
    sp = pick_sp();
    offer(pack_req(REQ_WRITE, REG_SP, sp, '0, '0));
    offer(pack_req(REQ_WRITE, REG_RA, $urandom, '0, '0));
    if ($urandom_range(0, 1)) offer(pack_req(REQ_WRITE, pick_sreg(), $urandom, '0, '0));
    offer(pack_req(REQ_CALL, '0, '0, '0, '0));
    repeat ($urandom_range(1, 5)) offer_body(sp);
    if (level < 2 && $urandom_range(0, 3) == 0) begin
      run_frame(level + 1);
      offer(pack_req(REQ_WRITE, REG_SP, sp, '0, '0));
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: offer(pack_req(REQ_WRITE, REG_SP, sp + 4, '0, '0));
        1: offer(pack_req(REQ_WRITE, REG_RA, $urandom, '0, '0));
        default: offer(pack_req(REQ_WRITE, pick_sreg(), $urandom, '0, '0));
      endcase
    end
    offer(pack_req(REQ_RET, '0, '0, '0, '0));
    if ($urandom_range(0, 1)) offer_body(sp);
  endtask

  // Short directed sequence over the special cases.
  task automatic run_directed();
    logic [31:0] base;
    base = cur_top - STACK_BYTES;
    offer(pack_req(REQ_RET, '0, '0, '0, '0));
    offer(pack_req(REQ_READ, 5'd0, '0, '0, '0));
    offer(pack_req(REQ_READ, 5'd5, '0, '0, '0));
    offer(pack_req(REQ_WRITE, 5'd5, 32'hFFFF_FFFF, '0, '0));
    offer(pack_req(REQ_WRITE, REG_SP, 32'd0, '0, '0));
    offer(pack_req(REQ_CALL, '0, '0, '0, '0));
    offer(pack_req(REQ_WRITE, REG_SP, base + 64, '0, '0));
    offer(pack_req(REQ_CALL, '0, '0, '0, '0));
    offer(pack_req(REQ_READ, 5'd5, '0, '0, '0));
    offer(pack_req(REQ_STORE, 5'd31, '0, base + 60, 4'd8));
    offer(pack_req(REQ_LOAD, '0, '0, base + 60, 4'd4));
    offer(pack_req(REQ_LOAD, '0, '0, base + 56, 4'd8));
    offer(pack_req(REQ_LOAD, '0, '0, base + 8, 4'd0));
    offer(pack_req(REQ_LOAD, '0, '0, 32'hFFFF_FFFF, 4'd15));
    offer(pack_req(REQ_SPARE_A, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    offer(pack_req(REQ_SPARE_B, '0, '0, '0, '0));
    offer(pack_req(REQ_WRITE, 5'd27, 32'h1234_5678, '0, '0));
    offer(pack_req(REQ_RET, '0, '0, '0, '0));
    offer(pack_req(REQ_CALL, '0, '0, '0, '0));
    offer(pack_req(REQ_WRITE, REG_RA, 32'hDEAD_BEEF, '0, '0));
    offer(pack_req(REQ_RET, '0, '0, '0, '0));
    offer(pack_req(REQ_CALL, '0, '0, '0, '0));
    offer(pack_req(REQ_WRITE, REG_SP, base + 32, '0, '0));
    offer(pack_req(REQ_RET, '0, '0, '0, '0));
  endtask

  // Pushes past the shadow stack depth, then unwinds beyond empty.
  task automatic run_overflow();
    offer(pack_req(REQ_WRITE, REG_SP, cur_top - STACK_BYTES + 16, '0, '0));
    repeat (FRAME_DEPTH + 2) offer(pack_req(REQ_CALL, '0, '0, '0, '0));
    repeat (FRAME_DEPTH + 2) offer(pack_req(REQ_RET, '0, '0, '0, '0));
  endtask

  task automatic run_random(input int count);
    int start;
    start = sent;
    while (sent - start < count) begin
      if ($urandom_range(0, 99) < 80) run_frame(0);
      else offer_noise();
    end
  endtask

  // Main sequence: reset, then phases under several register settings.
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    quiet_left = 0;
    cur_top = RESET_TOP_ADDR;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_TOP_ADDR, RESET_TOP_ADDR);
    run_directed();
    quiet_left = 60;
    run_random(60);
    run_overflow();
    drain();

    write_reg(CFG_TOP_ADDR, 32'hFFFF_FFFF);
    run_random(40);
    drain();

    write_reg(CFG_ENABLE, 32'd0);
    run_random(30);
    drain();

    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_TOP_ADDR, 32'h0000_4000);
    run_random(40);
    drain();

    write_reg(CFG_TOP_ADDR, 32'h0000_0000);
    run_random(30);
    drain();

    write_reg(CFG_TOP_ADDR, 32'h0000_0FFC);
    run_random(30);
    drain();

    $display("Sent %0d requests over six register settings; %0d responses checked,",
             sent, words_seen);
    $display("%0d of them reporting a convention violation.", errors_seen);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ccc_pkg.sv
sv/ccc_ctrl.sv
sv/ccc_dp.sv
sv/calling_convention_checker.sv
verif/ccc_scoreboard.sv
verif/tb_calling_convention_checker.sv
